FILE: rtl/rws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Roulette wheel selector package
// Shared opcodes, status codes, sequencer states and scan token flags.
// ----------------------------------------------------------------------------
package rws_pkg;

    // Width of the opcode carried on the input tuser.
    localparam int OPCODE_W = 2;
    // Width of the status code carried on the output tdata.
    localparam int STATUS_W = 2;

    // Operation requested by an input transaction.
    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_DRAW   = 2'd2
    } opcode_t;

    // Status returned with every result transaction.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_MULT = 2'd1,
        S_SCAN = 2'd2,
        S_DONE = 2'd3
    } state_t;

    // Control flags that travel with the draw token along the cell chain.
    typedef struct packed {
        logic valid;
        logic found;
    } scan_flags_t;

endpackage : rws_pkg
`default_nettype wire

FILE: rtl/rws_mult.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Roulette wheel target multiplier
// Bit-serial shift-and-add multiplier that scales the fitness total by the
// random fraction, one fraction bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module rws_mult #(
    parameter int SUM_W  = 22,
    parameter int RAND_W = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [SUM_W-1:0]  multiplicand,
    input  wire logic [RAND_W-1:0] multiplier,
    output logic                   done,
    output logic [SUM_W-1:0]       target
);

    localparam int PROD_W = SUM_W + RAND_W;
    localparam int CNT_W  = $clog2(RAND_W + 1);

    logic [PROD_W-1:0] acc_reg;
    logic [PROD_W-1:0] acc_next;
    logic [RAND_W-1:0] frac_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    // One Horner step: double the partial product and add the total when
    // the current fraction bit is set.
    always_comb begin
        acc_next = {acc_reg[PROD_W-2:0], 1'b0}
                 + (frac_reg[RAND_W-1] ? PROD_W'(multiplicand) : PROD_W'(0));
    end

    // Step counter and handshake flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(RAND_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg  <= '0;
            frac_reg <= multiplier;
        end else if (busy_reg) begin
            acc_reg  <= acc_next;
            frac_reg <= {frac_reg[RAND_W-2:0], 1'b0};
        end
    end

    // The product is held after the last step, so the target stays stable.
    assign done   = done_reg;
    assign target = acc_reg[PROD_W-1:RAND_W];

endmodule : rws_mult
`default_nettype wire

FILE: rtl/rws_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Roulette wheel cell
// Holds one cumulative fitness sum and tests it against the draw target as
// the scan token passes, then hands the token to the next cell.
// ----------------------------------------------------------------------------
module rws_cell #(
    parameter int IDX_W      = 6,
    parameter int CNT_W      = 7,
    parameter int SUM_W      = 22,
    parameter int CELL_INDEX = 0
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 wr_req,
    input  wire logic [CNT_W-1:0]     count,
    input  wire logic [SUM_W-1:0]     wr_sum,
    input  wire rws_pkg::scan_flags_t in_flags,
    input  wire logic [IDX_W-1:0]     in_index,
    input  wire logic [SUM_W-1:0]     in_target,
    output rws_pkg::scan_flags_t      out_flags,
    output logic [IDX_W-1:0]          out_index,
    output logic [SUM_W-1:0]          out_target
);

    import rws_pkg::*;

    logic [SUM_W-1:0] sum_reg;
    scan_flags_t      flags_reg;
    logic [IDX_W-1:0] index_reg;
    logic [SUM_W-1:0] target_reg;
    logic             occupied;
    logic             hit;

    // The entry is live while it lies below the population count.
    assign occupied = CNT_W'(CELL_INDEX) < count;
    assign hit      = in_flags.valid && !in_flags.found && occupied
                   && (sum_reg > in_target);

    // The append that lands on this entry stores the new running sum.
    always_ff @(posedge aclk) begin
        if (wr_req && (count == CNT_W'(CELL_INDEX))) begin
            sum_reg <= wr_sum;
        end
    end

    // Token flags carry control and are cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else begin
            flags_reg.valid <= in_flags.valid;
            flags_reg.found <= in_flags.found || hit;
        end
    end

    // Token payload; the first hit claims the index.
    always_ff @(posedge aclk) begin
        target_reg <= in_target;
        index_reg  <= hit ? IDX_W'(CELL_INDEX) : in_index;
    end

    assign out_flags  = flags_reg;
    assign out_index  = index_reg;
    assign out_target = target_reg;

endmodule : rws_cell
`default_nettype wire

FILE: rtl/roulette_wheel_selector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Roulette wheel selector
// Fitness-proportionate selection over a population held in a chain of cells.
// ----------------------------------------------------------------------------
// Each input transaction gives exactly one result transaction. Clear, append
// and unknown opcodes finish in the cycle they are accepted. A draw first runs
// the bit-serial multiplier that scales the fitness total by the random
// fraction, then lets the token walk the whole chain of cells, one cell per
// cycle, before the sequencer pushes the result. One item is in work at a
// time; a two-entry result buffer lets the block take new transactions while
// results wait downstream. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module roulette_wheel_selector #(
    parameter int POPULATION_MAX = 64,
    parameter int FITNESS_BITS   = 16,
    parameter int RANDOM_BITS    = 16
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    // Input stream.
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // tdata: fitness [FITNESS_BITS], random_fraction [RANDOM_BITS], zero pad.
    input  wire logic [((FITNESS_BITS + RANDOM_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // tuser: opcode.
    input  wire logic [rws_pkg::OPCODE_W-1:0] s_axis_tuser,
    // Result stream.
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // tdata: selected_index [clog2(POPULATION_MAX)], status [2], zero pad.
    output logic [(($clog2(POPULATION_MAX) + rws_pkg::STATUS_W + 7) / 8) * 8 - 1:0]
                      m_axis_tdata
);

    import rws_pkg::*;

    localparam int IDX_W = $clog2(POPULATION_MAX);
    localparam int CNT_W = $clog2(POPULATION_MAX + 1);
    localparam int SUM_W = FITNESS_BITS + IDX_W;

    // Sequencer and population state.
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]  total_reg, total_next;
    logic              inject_reg, inject_next;
    logic [IDX_W-1:0]  res_index_reg, res_index_next;

    // Result buffer: head drives the output, tail is the skid entry.
    logic              head_valid_reg, head_valid_next;
    logic [IDX_W-1:0]  head_index_reg, head_index_next;
    status_t           head_status_reg, head_status_next;
    logic              tail_valid_reg, tail_valid_next;
    logic [IDX_W-1:0]  tail_index_reg, tail_index_next;
    status_t           tail_status_reg, tail_status_next;

    logic              in_fire;
    logic              out_fire;
    opcode_t           opcode;
    logic [FITNESS_BITS-1:0] fitness;
    logic [RANDOM_BITS-1:0]  random_fraction;
    logic [SUM_W-1:0]  app_sum;
    logic              wr_req;
    logic              mult_start;
    logic              mult_done;
    logic [SUM_W-1:0]  mult_target;
    logic [CNT_W-1:0]  count_m1;
    logic              push;
    logic [IDX_W-1:0]  push_index;
    status_t           push_status;

    // Token chain between the cells; position zero is the injection point.
    scan_flags_t       chain_flags  [0:POPULATION_MAX];
    logic [IDX_W-1:0]  chain_index  [0:POPULATION_MAX];
    logic [SUM_W-1:0]  chain_target [0:POPULATION_MAX];

    // Unpack the input transaction.
    assign opcode          = opcode_t'(s_axis_tuser);
    assign fitness         = s_axis_tdata[FITNESS_BITS-1:0];
    assign random_fraction = s_axis_tdata[FITNESS_BITS +: RANDOM_BITS];

    assign s_axis_tready = (state_reg == S_IDLE) && !tail_valid_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = m_axis_tvalid && m_axis_tready;

    assign app_sum  = total_reg + SUM_W'(fitness);
    assign count_m1 = count_reg - CNT_W'(1);

    // Target multiplier.
    rws_mult #(
        .SUM_W  (SUM_W),
        .RAND_W (RANDOM_BITS)
    ) u_mult (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (mult_start),
        .multiplicand (total_reg),
        .multiplier   (random_fraction),
        .done         (mult_done),
        .target       (mult_target)
    );

    // The token enters the chain once the target is ready.
    assign chain_flags[0].valid = inject_reg;
    assign chain_flags[0].found = 1'b0;
    assign chain_index[0]       = '0;
    assign chain_target[0]      = mult_target;

    // Chain of cells, one per population entry.
    generate
        for (genvar gi = 0; gi < POPULATION_MAX; gi++) begin : g_cell
            rws_cell #(
                .IDX_W      (IDX_W),
                .CNT_W      (CNT_W),
                .SUM_W      (SUM_W),
                .CELL_INDEX (gi)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .wr_req     (wr_req),
                .count      (count_reg),
                .wr_sum     (app_sum),
                .in_flags   (chain_flags[gi]),
                .in_index   (chain_index[gi]),
                .in_target  (chain_target[gi]),
                .out_flags  (chain_flags[gi+1]),
                .out_index  (chain_index[gi+1]),
                .out_target (chain_target[gi+1])
            );
        end
    endgenerate

    // Sequencer: next state, population update and result production.
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        inject_next    = 1'b0;
        res_index_next = res_index_reg;
        wr_req         = 1'b0;
        mult_start     = 1'b0;
        push           = 1'b0;
        push_index     = '0;
        push_status    = STAT_OK;

        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    push = 1'b1;
                    case (opcode)
                        OP_CLEAR: begin
                            count_next = '0;
                            total_next = '0;
                        end
                        OP_APPEND: begin
                            if (count_reg == CNT_W'(POPULATION_MAX)) begin
                                push_status = STAT_FULL;
                            end else begin
                                wr_req     = 1'b1;
                                total_next = app_sum;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_DRAW: begin
                            if ((count_reg == '0) || (total_reg == '0)) begin
                                push_status = STAT_EMPTY;
                            end else begin
                                push       = 1'b0;
                                mult_start = 1'b1;
                                state_next = S_MULT;
                            end
                        end
                        default: begin
                            push_status = STAT_OK;
                        end
                    endcase
                end
            end
            S_MULT: begin
                if (mult_done) begin
                    inject_next = 1'b1;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (chain_flags[POPULATION_MAX].valid) begin
                    // With a nonzero total the last entry always exceeds the
                    // target; falling back to it covers a scan with no hit.
                    res_index_next = chain_flags[POPULATION_MAX].found
                                   ? chain_index[POPULATION_MAX]
                                   : count_m1[IDX_W-1:0];
                    state_next     = S_DONE;
                end
            end
            S_DONE: begin
                if (!tail_valid_reg) begin
                    push       = 1'b1;
                    push_index = res_index_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result buffer update.
    always_comb begin
        head_valid_next  = head_valid_reg;
        head_index_next  = head_index_reg;
        head_status_next = head_status_reg;
        tail_valid_next  = tail_valid_reg;
        tail_index_next  = tail_index_reg;
        tail_status_next = tail_status_reg;

        if (out_fire) begin
            if (tail_valid_reg) begin
                head_index_next  = tail_index_reg;
                head_status_next = tail_status_reg;
                tail_valid_next  = push;
                tail_index_next  = push_index;
                tail_status_next = push_status;
            end else begin
                head_valid_next  = push;
                head_index_next  = push_index;
                head_status_next = push_status;
            end
        end else if (push) begin
            if (!head_valid_reg) begin
                head_valid_next  = 1'b1;
                head_index_next  = push_index;
                head_status_next = push_status;
            end else begin
                tail_valid_next  = 1'b1;
                tail_index_next  = push_index;
                tail_status_next = push_status;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            total_reg      <= '0;
            inject_reg     <= 1'b0;
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            total_reg      <= total_next;
            inject_reg     <= inject_next;
            head_valid_reg <= head_valid_next;
            tail_valid_reg <= tail_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        res_index_reg   <= res_index_next;
        head_index_reg  <= head_index_next;
        head_status_reg <= head_status_next;
        tail_index_reg  <= tail_index_next;
        tail_status_reg <= tail_status_next;
    end

    // Pack the result transaction.
    always_comb begin
        m_axis_tdata                      = '0;
        m_axis_tdata[IDX_W-1:0]           = head_index_reg;
        m_axis_tdata[IDX_W +: STATUS_W]   = head_status_reg;
    end
    assign m_axis_tvalid = head_valid_reg;

    // The population never grows past its capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(POPULATION_MAX))
        else $error("population count exceeds capacity");

    // The skid entry is only filled behind a waiting head entry.
    a_tail_behind_head: assert property (@(posedge aclk) disable iff (!aresetn)
        tail_valid_reg |-> head_valid_reg)
        else $error("result skid entry valid without head entry");

    // The multiplier only finishes while the sequencer waits for it.
    a_mult_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mult_done |-> (state_reg == S_MULT))
        else $error("multiplier finished outside the multiply state");

    // A token leaving the chain is only seen while scanning.
    a_token_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        chain_flags[POPULATION_MAX].valid |-> (state_reg == S_SCAN))
        else $error("scan token left the chain outside the scan state");

    // A draw starts only from an idle sequencer with a nonempty population.
    a_draw_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        mult_start |-> ((count_reg != '0) && (total_reg != '0)))
        else $error("draw started on an empty population");

endmodule : roulette_wheel_selector
`default_nettype wire
